// File: rtl/sla_pkg.sv
// Shared constants, types and codes of the semi-Lagrangian advection block.
`default_nettype none
package sla_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int AXIS_BITS  = 5;
    localparam int MAX_CELLS  = 30;
    localparam int VAL_W      = 32;
    localparam int STEP_W     = 31;
    localparam int POS_W      = AXIS_BITS + FRAC_BITS;
    localparam int HALF_BITS  = AXIS_BITS - 1;
    localparam int BANK_AW    = 3 * HALF_BITS;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS  = 8;

    typedef enum logic [2:0] {
        REG_STEP_X = 3'd0,
        REG_STEP_Y = 3'd1,
        REG_STEP_Z = 3'd2,
        REG_SIZE_X = 3'd3,
        REG_SIZE_Y = 3'd4,
        REG_SIZE_Z = 3'd5
    } t_reg_idx;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_ADVECT = 1'b1;

    typedef struct packed {
        logic                 v;
        logic [AXIS_BITS-1:0] x;
        logic [AXIS_BITS-1:0] y;
        logic [AXIS_BITS-1:0] z;
    } t_meta;
endpackage
`default_nettype wire

// File: rtl/sla_bank.sv
// One bank of the source field: one write port, one registered read port.
`default_nettype none
module sla_bank
    import sla_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [BANK_AW-1:0] i_waddr,
    input  wire logic [VAL_W-1:0]   i_wdata,
    input  wire logic               i_re,
    input  wire logic [BANK_AW-1:0] i_raddr,
    output logic      [VAL_W-1:0]   o_q
);
    logic [VAL_W-1:0] r_mem [BANK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_q <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/sla_lerp.sv
// Two-stage linear interpolation a + trunc(t * (b - a)).
`default_nettype none
module sla_lerp
    import sla_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [VAL_W-1:0] i_a,
    input  wire logic signed [VAL_W-1:0] i_b,
    input  wire logic [FRAC_BITS-1:0]    i_t,
    output logic signed      [VAL_W-1:0] o_y
);
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]  r_a;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    logic signed [VAL_W+1:0]  sum;

    always_comb begin
        diff   = DIFF_W'(i_b) - DIFF_W'(i_a);
        n_prod = PROD_W'(diff) * $signed(PROD_W'({1'b0, i_t}));
    end

    // bias negative products so the shift truncates toward zero
    always_comb begin
        biased  = r_prod[PROD_W-1]
                  ? r_prod + PROD_W'((1 << FRAC_BITS) - 1) : r_prod;
        shifted = biased >>> FRAC_BITS;
        sum     = (VAL_W+2)'(r_a) + shifted[VAL_W+1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_a    <= i_a;
            o_y    <= sum[VAL_W-1:0];
        end
    end
endmodule
`default_nettype wire

// File: rtl/semi_lagrangian_trilinear_advect.sv
// Top level: back-trace, clamp, banked corner fetch and trilinear blend.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  input   | in        | i_valid / o_stall  | i_cmd, i_cell_xyz, i_write_value, i_vel
//  result  | out       | o_valid / i_stall  | o_sampled_value, o_out_x/y/z
//  config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One request per cycle while o_stall is low; an advect result passes through
// 3 trace stages, 1 bank read and 3 two-stage lerps. Eight parity banks give the
// eight corners in one read. A held result freezes the whole pipeline.
// Reset clears valid bits and config registers; the field is undefined until written.
`default_nettype none
module semi_lagrangian_trilinear_advect
    import sla_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_cmd,
    input  wire logic [AXIS_BITS-1:0]    i_cell_x,
    input  wire logic [AXIS_BITS-1:0]    i_cell_y,
    input  wire logic [AXIS_BITS-1:0]    i_cell_z,
    input  wire logic signed [VAL_W-1:0] i_write_value,
    input  wire logic signed [VAL_W-1:0] i_vel_x,
    input  wire logic signed [VAL_W-1:0] i_vel_y,
    input  wire logic signed [VAL_W-1:0] i_vel_z,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [VAL_W-1:0]      o_sampled_value,
    output logic [AXIS_BITS-1:0]         o_out_x,
    output logic [AXIS_BITS-1:0]         o_out_y,
    output logic [AXIS_BITS-1:0]         o_out_z,
    input  wire logic                    i_cfg_we,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [STEP_W-1:0]       i_cfg_data
);
    localparam int P_W   = VAL_W + STEP_W - FRAC_BITS;
    localparam int EXT_W = P_W + 2;
    localparam int DLY   = 6;

    logic en;

    // configuration
    logic [STEP_W-1:0]    r_step [3];
    logic [AXIS_BITS-1:0] r_size [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_step[a] <= '0;
                r_size[a] <= AXIS_BITS'(MAX_CELLS);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STEP_X: r_step[0] <= i_cfg_data;
                REG_STEP_Y: r_step[1] <= i_cfg_data;
                REG_STEP_Z: r_step[2] <= i_cfg_data;
                REG_SIZE_X: r_size[0] <= i_cfg_data[AXIS_BITS-1:0];
                REG_SIZE_Y: r_size[1] <= i_cfg_data[AXIS_BITS-1:0];
                REG_SIZE_Z: r_size[2] <= i_cfg_data[AXIS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: capture, velocity magnitude
    logic                 r1_v, r1_cmd;
    logic [AXIS_BITS-1:0] r1_cell [3];
    logic [VAL_W-1:0]     r1_wv;
    logic [VAL_W-1:0]     r1_mag [3];
    logic                 r1_neg [3];
    logic [VAL_W-1:0]     vel [3];

    assign vel[0] = i_vel_x;
    assign vel[1] = i_vel_y;
    assign vel[2] = i_vel_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd     <= i_cmd;
            r1_cell[0] <= i_cell_x;
            r1_cell[1] <= i_cell_y;
            r1_cell[2] <= i_cell_z;
            r1_wv      <= i_write_value;
            for (int a = 0; a < 3; a++) begin
                r1_neg[a] <= vel[a][VAL_W-1];
                r1_mag[a] <= vel[a][VAL_W-1] ? (~vel[a] + 1'b1) : vel[a];
            end
        end
    end

    // stage 2: step times speed, truncated
    logic                 r2_v, r2_cmd;
    logic [AXIS_BITS-1:0] r2_cell [3];
    logic [VAL_W-1:0]     r2_wv;
    logic [P_W-1:0]       r2_p [3];
    logic                 r2_neg [3];
    logic [VAL_W+STEP_W-1:0] prod [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a] = (VAL_W+STEP_W)'(r1_mag[a]) * (VAL_W+STEP_W)'(r_step[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_cmd <= r1_cmd;
            r2_wv  <= r1_wv;
            for (int a = 0; a < 3; a++) begin
                r2_cell[a] <= r1_cell[a];
                r2_neg[a]  <= r1_neg[a];
                r2_p[a]    <= prod[a][VAL_W+STEP_W-1:FRAC_BITS];
            end
        end
    end

    // stage 3: trace back and clamp
    logic                 r3_v, r3_cmd;
    logic [AXIS_BITS-1:0] r3_cell [3];
    logic [VAL_W-1:0]     r3_wv;
    logic [POS_W-1:0]     r3_pos [3];
    logic [POS_W-1:0]     n_pos [3];

    function automatic logic [AXIS_BITS-1:0] sat_size(input logic [AXIS_BITS-1:0] s);
        logic [AXIS_BITS-1:0] r;
        r = s;
        if (s == '0) r = AXIS_BITS'(1);
        else if (s > AXIS_BITS'(MAX_CELLS)) r = AXIS_BITS'(MAX_CELLS);
        return r;
    endfunction

    always_comb begin
        logic signed [EXT_W-1:0] base, pos, lo, hi;
        for (int a = 0; a < 3; a++) begin
            base = $signed(EXT_W'({r2_cell[a], {FRAC_BITS{1'b0}}}));
            pos  = r2_neg[a] ? base + $signed(EXT_W'(r2_p[a]))
                             : base - $signed(EXT_W'(r2_p[a]));
            lo   = $signed(EXT_W'(1 << (FRAC_BITS - 1)));
            hi   = $signed(EXT_W'({sat_size(r_size[a]), {FRAC_BITS{1'b0}}})) + lo;
            if (pos < lo) pos = lo;
            if (pos > hi) pos = hi;
            n_pos[a] = pos[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_cmd <= r2_cmd;
            r3_wv  <= r2_wv;
            for (int a = 0; a < 3; a++) begin
                r3_cell[a] <= r2_cell[a];
                r3_pos[a]  <= n_pos[a];
            end
        end
    end

    // banked field: bank = parity of x, y, z; address = halved coordinates
    logic [NUM_BANKS-1:0] bank_we;
    logic [BANK_AW-1:0]   waddr;
    logic [BANK_AW-1:0]   raddr [NUM_BANKS];
    logic [VAL_W-1:0]     bank_q [NUM_BANKS];
    logic [2:0]           wbank;

    assign wbank = {r3_cell[2][0], r3_cell[1][0], r3_cell[0][0]};
    assign waddr = {r3_cell[2][AXIS_BITS-1:1], r3_cell[1][AXIS_BITS-1:1],
                    r3_cell[0][AXIS_BITS-1:1]};

    always_comb begin
        logic [AXIS_BITS-1:0] base, crd;
        logic [HALF_BITS-1:0] h [3];
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_we[b] = en && r3_v && (r3_cmd == CMD_WRITE) && (wbank == 3'(b));
            for (int a = 0; a < 3; a++) begin
                base = r3_pos[a][POS_W-1:FRAC_BITS];
                // corner on this parity is the floor or the floor plus one
                crd  = (base[0] == b[a]) ? base : base + 1'b1;
                h[a] = crd[AXIS_BITS-1:1];
            end
            raddr[b] = {h[2], h[1], h[0]};
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        sla_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[b]),
            .i_waddr (waddr),
            .i_wdata (r3_wv),
            .i_re    (en),
            .i_raddr (raddr[b]),
            .o_q     (bank_q[b])
        );
    end

    // stage 4: corner data arrives with the fractions
    t_meta                r4_meta;
    logic [2:0]           r4_par;
    logic [FRAC_BITS-1:0] r4_t [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_meta.v <= 1'b0;
        end else if (en) begin
            r4_meta.v <= r3_v && (r3_cmd == CMD_ADVECT);
            r4_meta.x <= r3_cell[0];
            r4_meta.y <= r3_cell[1];
            r4_meta.z <= r3_cell[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r4_par[a] <= r3_pos[a][FRAC_BITS];
                r4_t[a]   <= r3_pos[a][FRAC_BITS-1:0];
            end
        end
    end

    // corner (dx,dy,dz) sits in bank parity ^ offset
    logic signed [VAL_W-1:0] corner [NUM_BANKS];
    always_comb begin
        for (int c = 0; c < NUM_BANKS; c++) begin
            corner[c] = bank_q[3'(c) ^ r4_par];
        end
    end

    logic [FRAC_BITS-1:0] r_ty [2];
    logic [FRAC_BITS-1:0] r_tz [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ty[0] <= r4_t[1];
            r_ty[1] <= r_ty[0];
            r_tz[0] <= r4_t[2];
            for (int i = 1; i < 4; i++) begin
                r_tz[i] <= r_tz[i-1];
            end
        end
    end

    logic signed [VAL_W-1:0] cx [4];
    logic signed [VAL_W-1:0] cy [2];

    for (genvar j = 0; j < 4; j++) begin : g_lx
        sla_lerp u_lx (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (corner[2*j]),
            .i_b   (corner[2*j+1]),
            .i_t   (r4_t[0]),
            .o_y   (cx[j])
        );
    end

    for (genvar j = 0; j < 2; j++) begin : g_ly
        sla_lerp u_ly (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (cx[2*j]),
            .i_b   (cx[2*j+1]),
            .i_t   (r_ty[1]),
            .o_y   (cy[j])
        );
    end

    sla_lerp u_lz (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (cy[0]),
        .i_b   (cy[1]),
        .i_t   (r_tz[3]),
        .o_y   (o_sampled_value)
    );

    // metadata follows the blend
    t_meta r_dly [DLY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DLY; i++) begin
                r_dly[i].v <= 1'b0;
            end
        end else if (en) begin
            r_dly[0] <= r4_meta;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign en      = !r_dly[DLY-1].v || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_dly[DLY-1].v;
    assign o_out_x = r_dly[DLY-1].x;
    assign o_out_y = r_dly[DLY-1].y;
    assign o_out_z = r_dly[DLY-1].z;

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow a held result");

    a_one_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(bank_we))
        else $error("more than one bank written");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v && (r3_cmd == CMD_ADVECT) |->
            (r3_pos[0] >= POS_W'(1 << (FRAC_BITS - 1))) &&
            (r3_pos[0][POS_W-1:FRAC_BITS] <= AXIS_BITS'(MAX_CELLS)))
        else $error("traced x position outside clamp");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r4_meta.v) && $stable(r1_v))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// File: tb/sv/semi_lagrangian_trilinear_advect_tb.sv
// Testbench for the semi-Lagrangian trilinear advection block: field load, advect checks.
`timescale 1ns / 100ps
`default_nettype none
module semi_lagrangian_trilinear_advect_tb;
    import sla_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  DRAIN_WAIT  = 24;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  FIELD_WORDS = 1 << (3 * AXIS_BITS);
    // loaded field: full x range, y and z from 0 to LOAD_YZ - 1
    localparam int  LOAD_YZ     = 3;
    // corner reads reach size + 1, so y and z sizes stay within the load
    localparam int  YZ_SIZE_MAX = LOAD_YZ - 2;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [AXIS_BITS-1:0]    x;
        logic [AXIS_BITS-1:0]    y;
        logic [AXIS_BITS-1:0]    z;
    } t_sample;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_cmd;
    logic [AXIS_BITS-1:0]    i_cell_x;
    logic [AXIS_BITS-1:0]    i_cell_y;
    logic [AXIS_BITS-1:0]    i_cell_z;
    logic signed [VAL_W-1:0] i_write_value;
    logic signed [VAL_W-1:0] i_vel_x;
    logic signed [VAL_W-1:0] i_vel_y;
    logic signed [VAL_W-1:0] i_vel_z;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [VAL_W-1:0] o_sampled_value;
    logic [AXIS_BITS-1:0]    o_out_x;
    logic [AXIS_BITS-1:0]    o_out_y;
    logic [AXIS_BITS-1:0]    o_out_z;
    logic                    i_cfg_we;
    logic [2:0]              i_cfg_index;
    logic [STEP_W-1:0]       i_cfg_data;

    semi_lagrangian_trilinear_advect u_top (.*);

    // shadow of the block's field and registers
    logic [VAL_W-1:0]     field_mem [FIELD_WORDS];
    logic [STEP_W-1:0]    step_reg [3];
    logic [AXIS_BITS-1:0] size_reg [3];

    t_sample pending_samples[$];
    int      mismatches;
    int      cycles;
    int      advects_sent;
    int      writes_sent;
    int      samples_checked;
    int      burst_left;

    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = 1'b1;
            #CLK_HALF i_clk = 1'b0;
        end
    end

    function automatic longint scale_trunc(longint x, longint unsigned t);
        longint unsigned m;
        longint unsigned p;
        m = (x < 0) ? longint'(-x) : longint'(x);
        p = (m * t) >> FRAC_BITS;
        return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint blend(longint a, longint b, longint unsigned t);
        return a + scale_trunc(b - a, t);
    endfunction

    function automatic longint cell_value(int x, int y, int z);
        logic [VAL_W-1:0] w;
        w = field_mem[{z[AXIS_BITS-1:0], y[AXIS_BITS-1:0], x[AXIS_BITS-1:0]}];
        return longint'($signed(w));
    endfunction

    // back-trace one axis, clamped to [0.5, size + 0.5]
    function automatic longint trace_back(int axis, logic [AXIS_BITS-1:0] cell_idx,
                                          logic signed [VAL_W-1:0] vel);
        longint pos;
        longint hi;
        int     eff;
        eff = size_reg[axis];
        if (eff < 1) eff = 1;
        if (eff > MAX_CELLS) eff = MAX_CELLS;
        pos = (longint'(cell_idx) <<< FRAC_BITS) -
              scale_trunc(longint'(vel), longint'(step_reg[axis]));
        hi  = (longint'(eff) <<< FRAC_BITS) + (longint'(1) <<< (FRAC_BITS - 1));
        if (pos < (longint'(1) <<< (FRAC_BITS - 1))) pos = longint'(1) <<< (FRAC_BITS - 1);
        if (pos > hi) pos = hi;
        return pos;
    endfunction

    function automatic logic signed [VAL_W-1:0] advect_sample(
        logic [AXIS_BITS-1:0] cx, logic [AXIS_BITS-1:0] cy, logic [AXIS_BITS-1:0] cz,
        logic signed [VAL_W-1:0] vx, logic signed [VAL_W-1:0] vy,
        logic signed [VAL_W-1:0] vz);
        longint px, py, pz;
        int     i0, j0, k0;
        longint unsigned tx, ty, tz;
        longint c00, c10, c01, c11, c0, c1, v;
        px = trace_back(0, cx, vx);
        py = trace_back(1, cy, vy);
        pz = trace_back(2, cz, vz);
        i0 = int'(px >>> FRAC_BITS);
        j0 = int'(py >>> FRAC_BITS);
        k0 = int'(pz >>> FRAC_BITS);
        tx = px & ((longint'(1) <<< FRAC_BITS) - 1);
        ty = py & ((longint'(1) <<< FRAC_BITS) - 1);
        tz = pz & ((longint'(1) <<< FRAC_BITS) - 1);
        c00 = blend(cell_value(i0, j0, k0),         cell_value(i0 + 1, j0, k0), tx);
        c10 = blend(cell_value(i0, j0 + 1, k0),     cell_value(i0 + 1, j0 + 1, k0), tx);
        c01 = blend(cell_value(i0, j0, k0 + 1),     cell_value(i0 + 1, j0, k0 + 1), tx);
        c11 = blend(cell_value(i0, j0 + 1, k0 + 1), cell_value(i0 + 1, j0 + 1, k0 + 1), tx);
        c0  = blend(c00, c10, ty);
        c1  = blend(c01, c11, ty);
        v   = blend(c0, c1, tz);
        return v[VAL_W-1:0];
    endfunction

    // one request; returns after acceptance with valid still high
    task automatic send_request(logic cmd, logic [AXIS_BITS-1:0] cx,
                                logic [AXIS_BITS-1:0] cy, logic [AXIS_BITS-1:0] cz,
                                logic signed [VAL_W-1:0] wval,
                                logic signed [VAL_W-1:0] vx,
                                logic signed [VAL_W-1:0] vy,
                                logic signed [VAL_W-1:0] vz);
        t_sample s;
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        i_valid       = 1'b1;
        i_cmd         = cmd;
        i_cell_x      = cx;
        i_cell_y      = cy;
        i_cell_z      = cz;
        i_write_value = wval;
        i_vel_x       = vx;
        i_vel_y       = vy;
        i_vel_z       = vz;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (cmd == CMD_WRITE) begin
            field_mem[{cz, cy, cx}] = wval;
            writes_sent++;
        end else begin
            s.value = advect_sample(cx, cy, cz, vx, vy, vz);
            s.x = cx;
            s.y = cy;
            s.z = cz;
            pending_samples.push_back(s);
            advects_sent++;
        end
        @(negedge i_clk);
    endtask

    // sender stops until every result is back and the pipe is empty
    task automatic drain_block();
        i_valid = 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [STEP_W-1:0] data);
        drain_block();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_STEP_X: step_reg[0] = data;
            REG_STEP_Y: step_reg[1] = data;
            REG_STEP_Z: step_reg[2] = data;
            REG_SIZE_X: size_reg[0] = data[AXIS_BITS-1:0];
            REG_SIZE_Y: size_reg[1] = data[AXIS_BITS-1:0];
            REG_SIZE_Z: size_reg[2] = data[AXIS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_steps(logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy,
                             logic [STEP_W-1:0] sz);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_STEP_Z, sz);
    endtask

    task automatic set_sizes(logic [AXIS_BITS-1:0] sx, logic [AXIS_BITS-1:0] sy,
                             logic [AXIS_BITS-1:0] sz);
        write_reg(REG_SIZE_X, STEP_W'(sx));
        write_reg(REG_SIZE_Y, STEP_W'(sy));
        write_reg(REG_SIZE_Z, STEP_W'(sz));
    endtask

    function automatic logic signed [VAL_W-1:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return VAL_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return VAL_W'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return VAL_W'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] rand_step();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return STEP_W'($urandom);
            default: return STEP_W'($urandom_range(0, 3 << FRAC_BITS));
        endcase
    endfunction

    // every cell that an advect can reach is written once before any advect
    task automatic test_field_load();
        for (int z = 0; z < LOAD_YZ; z++) begin
            for (int y = 0; y < LOAD_YZ; y++) begin
                for (int x = 0; x < (1 << AXIS_BITS); x++) begin
                    logic signed [VAL_W-1:0] val;
                    case ($urandom_range(0, 7))
                        0: val = 32'sh7FFF_FFFF;
                        1: val = 32'sh8000_0000;
                        2: val = $urandom;
                        default: val = VAL_W'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
                    endcase
                    send_request(CMD_WRITE, AXIS_BITS'(x), AXIS_BITS'(y), AXIS_BITS'(z),
                                 val, $urandom, $urandom, $urandom);
                end
            end
        end
    endtask

    task automatic test_directed();
        // y and z stay at one interior cell so corners remain in the loaded field
        set_sizes(5'd30, 5'd1, 5'd0);
        // zero step: sample lands on the cell itself, clamped at the ghost layer
        send_request(CMD_ADVECT, 5'd0, 5'd0, 5'd0, 0, 0, 0, 0);
        send_request(CMD_ADVECT, 5'd31, 5'd31, 5'd31, 0, 0, 0, 0);
        send_request(CMD_ADVECT, 5'd7, 5'd12, 5'd20, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        set_steps(STEP_W'(1 << FRAC_BITS), STEP_W'(1 << (FRAC_BITS - 1)), '1);
        send_request(CMD_ADVECT, 5'd15, 5'd15, 5'd15, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF);
        send_request(CMD_ADVECT, 5'd15, 5'd15, 5'd15, 0, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000);
        send_request(CMD_ADVECT, 5'd10, 5'd10, 5'd10, 0, 32'sh0001_8000, 32'sh0000_4000,
                     32'shFFFF_FFFF);
        // write immediately followed by an advect that reads it
        send_request(CMD_WRITE, 5'd10, 5'd1, 5'd1, 32'sh7FFF_FFFF, 0, 0, 0);
        send_request(CMD_WRITE, 5'd9, 5'd1, 5'd1, 32'sh8000_0000, 0, 0, 0);
        send_request(CMD_ADVECT, 5'd10, 5'd1, 5'd1, 0, 32'sh0000_8000, 0, 0);
        // size zero counts as one, size 31 counts as the maximum
        set_sizes(5'd0, 5'd0, 5'd1);
        send_request(CMD_ADVECT, 5'd31, 5'd31, 5'd31, 0, 0, 0, 0);
        send_request(CMD_ADVECT, 5'd2, 5'd0, 5'd3, 0, 32'sh8000_0000, 32'sh8000_0000, 0);
        send_request(CMD_ADVECT, 5'd30, 5'd1, 5'd0, 0, 32'sh0000_1234, 32'sh0003_0000,
                     32'sh7FFF_FFFF);
        set_sizes(5'd31, 5'd1, 5'd0);
        send_request(CMD_ADVECT, 5'd31, 5'd31, 5'd31, 0, 0, 0, 0);
        send_request(CMD_ADVECT, 5'd0, 5'd5, 5'd5, 0, 32'sh8000_0000, 0, 0);
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            set_steps(rand_step(), rand_step(), rand_step());
            if (p % 2 == 1)
                set_sizes(5'($urandom), 5'($urandom_range(0, YZ_SIZE_MAX)),
                          5'($urandom_range(0, YZ_SIZE_MAX)));
            else
                set_sizes(5'($urandom_range(1, 30)), 5'($urandom_range(0, YZ_SIZE_MAX)),
                          5'($urandom_range(0, YZ_SIZE_MAX)));
            for (int n = 0; n < per_phase; n++) begin
                if (n == per_phase / 2) drain_block();
                if ($urandom_range(0, 3) == 0)
                    send_request(CMD_WRITE, 5'($urandom), 5'($urandom), 5'($urandom),
                                 $urandom, $urandom, $urandom, $urandom);
                else
                    send_request(CMD_ADVECT, 5'($urandom), 5'($urandom), 5'($urandom),
                                 $urandom, rand_vel(), rand_vel(), rand_vel());
            end
        end
    endtask

    // receiver stall pattern, changing character in turn among four modes
    always @(negedge i_clk) begin
        case ((cycles / 64) % 4)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 9) < 3);
            2: i_stall = ($urandom_range(0, 9) < 7);
            default: i_stall = (cycles % 5) < 2;
        endcase
    end

    always @(posedge i_clk) begin
        t_sample e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_samples.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h (%0d,%0d,%0d)",
                         $time, o_sampled_value, o_out_x, o_out_y, o_out_z);
            end else begin
                e = pending_samples.pop_front();
                samples_checked++;
                if (o_sampled_value !== e.value || o_out_x !== e.x || o_out_y !== e.y ||
                    o_out_z !== e.z) begin
                    mismatches++;
                    $display("%0t: expected %h (%0d,%0d,%0d), actual %h (%0d,%0d,%0d)",
                             $time, e.value, e.x, e.y, e.z, o_sampled_value, o_out_x,
                             o_out_y, o_out_z);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_cmd = CMD_WRITE;
        i_cell_x = '0; i_cell_y = '0; i_cell_z = '0;
        i_write_value = '0; i_vel_x = '0; i_vel_y = '0; i_vel_z = '0;
        i_stall = 1'b0; i_cfg_we = 1'b0; i_cfg_index = REG_STEP_X; i_cfg_data = '0;
        mismatches = 0; cycles = 0; advects_sent = 0; writes_sent = 0;
        samples_checked = 0; burst_left = 0;
        step_reg[0] = '0; step_reg[1] = '0; step_reg[2] = '0;
        size_reg[0] = 5'd30; size_reg[1] = 5'd30; size_reg[2] = 5'd30;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_field_load();
        test_directed();
        test_random(4, 75);
        drain_block();

        $display("Loaded %0d field words in total, checked %0d of %0d advect samples",
                 writes_sent, samples_checked, advects_sent);
        $display("over four step/size settings with both channels idling at random");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
